FILE: sv/periodic_job_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
// Define SYNTH to compile the checks out.
`ifndef PERIODIC_JOB_SCHEDULER_DEFINES_SVH
`define PERIODIC_JOB_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
`define PJS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("periodic_job_scheduler: same-cycle check failed");
`define PJS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("periodic_job_scheduler: next-cycle check failed");
`else
`define PJS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PJS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/pjs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pjs_pkg;

    localparam int MAX_OUT = 8;

    typedef enum logic [1:0] {
        FN_TICK = 2'd0,
        FN_ADD  = 2'd1,
        FN_DEL  = 2'd2,
        FN_SET  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_USED     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NONE_DUE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_DEC,
        ST_SCAN,
        ST_EMIT,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic [6:0] prio;
        logic [7:0] period;
        logic [7:0] countdown;
        logic [7:0] remaining;
        logic       cont;
    } t_rec;

    typedef struct packed {
        logic [2:0] slot;
        t_status    status;
        logic       last;
    } t_result;

    // period 0 reloads as 1
    function automatic logic [7:0] load_value(input logic [7:0] period);
        return (period == 8'd0) ? 8'd1 : period;
    endfunction

endpackage

`default_nettype wire

FILE: sv/pjs_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module pjs_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pjs_pkg::t_result i_res,
    output logic             o_free,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [2:0] run_slot, [7:3] zero
    output logic [1:0]       m_axis_tuser,  // [1:0] status
    output logic             m_axis_tlast
);
    import pjs_pkg::*;

    logic    r_vld;
    t_result r_res;

    // a new word may enter while the held one leaves
    assign o_free = !r_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_push) begin
            r_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = {5'd0, r_res.slot};
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tlast  = r_res.last;

endmodule

`default_nettype wire

FILE: sv/periodic_job_scheduler.sv
// Periodic job scheduler: a table of NUM_SLOTS job slots driven by a word stream.
// Input words (s_axis): tuser carries the function (tick, add, delete, set),
// tdata the slot and job fields. Output words (m_axis): tdata carries the slot
// that runs, tuser the status, tlast marks the final word caused by one input.
// Add, delete and set give one word; a tick gives one word per job it runs
// (up to 8), or a single "nothing due" word.
// One input word is worked on at a time; s_axis_tready is low until its final
// result sits in the output register. The job fields of all slots live in one
// RAM with a registered read port, walked by a single compare/decrement unit.
// Steps from acceptance until ready again:
//   add, delete: accept, then the reply word; set (read-modify-write): read,
//   write, then the reply word; tick: accept, a countdown pass, a scan pass
//   and an emit per job run, a closing pass that finds nothing (skipped after
//   8 runs), then the final word.
// The output register keeps the next word moving while the receiver holds
// m_axis_tready low; the sequencer waits for it only when it has another
// word to hand over. Reset (synchronous, i_rst_n low) empties all slots and
// the output register; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_job_scheduler_defines.svh"

module periodic_job_scheduler #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] slot_index, [9:3] job_priority, [17:10] job_period,
    // [25:18] run_count, [26] run_forever, [31:27] zero
    input  logic [31:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] run_slot, [7:3] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);
    import pjs_pkg::*;

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] SLOTS_P = PW'(NUM_SLOTS);

    // input fields
    t_func      w_func;
    logic [2:0] w_idx3;
    logic [6:0] w_prio;
    logic [7:0] w_per;
    logic [7:0] w_cnt;
    logic       w_forever;
    logic       w_in_range;
    logic [AW-1:0] w_idx;
    logic       w_accept;

    assign w_func     = t_func'(s_axis_tuser);
    assign w_idx3     = s_axis_tdata[2:0];
    assign w_prio     = s_axis_tdata[9:3];
    assign w_per      = s_axis_tdata[17:10];
    assign w_cnt      = s_axis_tdata[25:18];
    assign w_forever  = s_axis_tdata[26];
    assign w_in_range = 32'(w_idx3) < 32'(NUM_SLOTS);
    assign w_idx      = AW'(w_idx3);
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    // state
    t_state r_state, n_state;
    logic [NUM_SLOTS-1:0] r_valid;
    logic [NUM_SLOTS-1:0] r_fresh;
    logic [PW-1:0] r_ptr;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_slot;
    logic [AW-1:0] r_idx;
    logic [6:0]    r_prio;
    logic [7:0]    r_per;
    logic          r_best_found;
    logic [AW-1:0] r_best_slot;
    t_rec          r_best_rec;
    logic [3:0]    r_emit_cnt;
    logic [AW-1:0] r_reply_slot;
    t_status       r_reply_status;

    // slot RAM
    t_rec r_mem [NUM_SLOTS];
    t_rec r_rd_data;
    logic          w_mem_we;
    logic [AW-1:0] w_wr_addr;
    t_rec          w_wr_data;
    logic [AW-1:0] w_rd_addr;

    // output stage
    logic    w_push;
    t_result w_push_res;
    logic    w_out_free;

    // scan datapath
    logic w_issue;
    logic w_scan_done;
    logic w_cur_valid;
    logic w_dec_we;
    logic w_due;
    logic w_better;
    logic w_emit_go;

    assign w_issue     = ((r_state == ST_DEC) || (r_state == ST_SCAN)) && (r_ptr < SLOTS_P);
    assign w_scan_done = (r_ptr == SLOTS_P) && !r_rd_vld;
    assign w_cur_valid = r_valid[r_rd_slot];
    assign w_dec_we    = r_rd_vld && w_cur_valid && !r_fresh[r_rd_slot]
                         && (r_rd_data.countdown != 8'd0);
    assign w_due       = r_rd_vld && w_cur_valid
                         && (r_rd_data.cont || (r_rd_data.remaining != 8'd0))
                         && (r_rd_data.countdown == 8'd0);
    // strict compare in ascending slot order: lower slot wins ties
    assign w_better    = w_due && (!r_best_found || (r_rd_data.prio < r_best_rec.prio));
    // the first run of a tick is held back until we know whether it is the last
    assign w_emit_go   = (r_emit_cnt == 4'd0) || w_out_free;

    always_comb begin
        priority if ((r_state == ST_IDLE) && w_in_range) begin
            w_rd_addr = w_idx;
        end else if (w_issue) begin
            w_rd_addr = r_ptr[AW-1:0];
        end else begin
            w_rd_addr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    priority if (w_func == FN_TICK) begin
                        n_state = ST_DEC;
                    end else if ((w_func == FN_SET) && w_in_range && r_valid[w_idx]) begin
                        n_state = ST_SET;
                    end else begin
                        n_state = ST_REPLY;
                    end
                end
            end
            ST_SET: begin
                n_state = ST_REPLY;
            end
            ST_DEC: begin
                if (w_scan_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = r_best_found ? ST_EMIT : ST_REPLY;
                end
            end
            ST_EMIT: begin
                if (w_emit_go) begin
                    n_state = (r_emit_cnt == 4'(MAX_OUT - 1)) ? ST_REPLY : ST_SCAN;
                end
            end
            ST_REPLY: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_mem_we   = 1'b0;
        w_wr_addr  = '0;
        w_wr_data  = r_rd_data;
        w_push     = 1'b0;
        w_push_res = '{slot: 3'(r_reply_slot), status: r_reply_status, last: 1'b1};
        s_axis_tready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_func == FN_ADD) && w_in_range && !r_valid[w_idx]) begin
                    w_mem_we  = 1'b1;
                    w_wr_addr = w_idx;
                    w_wr_data = '{prio: w_prio, period: w_per, countdown: load_value(w_per),
                                  remaining: w_cnt, cont: w_forever};
                end
            end
            ST_SET: begin
                // countdown is kept; only period and priority change
                w_mem_we         = 1'b1;
                w_wr_addr        = r_idx;
                w_wr_data.prio   = r_prio;
                w_wr_data.period = r_per;
            end
            ST_DEC: begin
                if (w_dec_we) begin
                    w_mem_we            = 1'b1;
                    w_wr_addr           = r_rd_slot;
                    w_wr_data.countdown = r_rd_data.countdown - 8'd1;
                end
            end
            ST_SCAN: begin
            end
            ST_EMIT: begin
                if (w_emit_go) begin
                    w_mem_we            = 1'b1;
                    w_wr_addr           = r_best_slot;
                    w_wr_data           = r_best_rec;
                    w_wr_data.countdown = load_value(r_best_rec.period);
                    if (!r_best_rec.cont) begin
                        w_wr_data.remaining = r_best_rec.remaining - 8'd1;
                    end
                    // the previous run is now known not to be the last
                    w_push          = (r_emit_cnt != 4'd0);
                    w_push_res.last = 1'b0;
                end
            end
            ST_REPLY: begin
                w_push = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_valid      <= '0;
            r_fresh      <= '0;
            r_ptr        <= '0;
            r_rd_vld     <= 1'b0;
            r_emit_cnt   <= '0;
            r_best_found <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_issue;

            if (w_accept && (w_func == FN_TICK)) begin
                r_ptr      <= '0;
                r_emit_cnt <= '0;
            end else if ((r_state == ST_DEC) && w_scan_done) begin
                r_ptr        <= '0;
                r_best_found <= 1'b0;
            end else if ((r_state == ST_EMIT) && w_emit_go) begin
                r_ptr        <= '0;
                r_best_found <= 1'b0;
                r_emit_cnt   <= r_emit_cnt + 4'd1;
            end else if (w_issue) begin
                r_ptr <= r_ptr + PW'(1);
            end

            if ((r_state == ST_SCAN) && w_better) begin
                r_best_found <= 1'b1;
            end

            if (w_accept && w_in_range && (w_func == FN_ADD) && !r_valid[w_idx]) begin
                r_valid[w_idx] <= 1'b1;
                r_fresh[w_idx] <= 1'b1;
            end
            if (w_accept && w_in_range && (w_func == FN_DEL) && r_valid[w_idx]) begin
                r_valid[w_idx] <= 1'b0;
                r_fresh[w_idx] <= 1'b0;
            end
            if ((r_state == ST_DEC) && r_rd_vld) begin
                r_fresh[r_rd_slot] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_slot <= r_ptr[AW-1:0];
        end
        if ((r_state == ST_SCAN) && w_better) begin
            r_best_slot <= r_rd_slot;
            r_best_rec  <= r_rd_data;
        end
        if (w_accept) begin
            r_idx        <= w_idx;
            r_prio       <= w_prio;
            r_per        <= w_per;
            r_reply_slot <= '0;
            priority if (w_func == FN_TICK) begin
                r_reply_status <= STAT_NONE_DUE;
            end else if (!w_in_range) begin
                r_reply_status <= STAT_EMPTY;
            end else if (w_func == FN_ADD) begin
                r_reply_status <= r_valid[w_idx] ? STAT_USED : STAT_OK;
            end else begin
                r_reply_status <= r_valid[w_idx] ? STAT_OK : STAT_EMPTY;
            end
        end else if ((r_state == ST_EMIT) && w_emit_go) begin
            r_reply_slot   <= r_best_slot;
            r_reply_status <= STAT_OK;
        end
    end

    pjs_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push),
        .i_res         (w_push_res),
        .o_free        (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    `PJS_ASSERT_IMPLY(a_emit_has_best, i_clk, i_rst_n, r_state == ST_EMIT, r_best_found)
    `PJS_ASSERT_IMPLY(a_emit_cnt_max, i_clk, i_rst_n, 1'b1, r_emit_cnt <= 4'(MAX_OUT))
    `PJS_ASSERT_IMPLY(a_mid_word_ok, i_clk, i_rst_n,
                      w_push && !w_push_res.last, w_push_res.status == STAT_OK)
    `PJS_ASSERT_IMPLY(a_scan_no_fresh, i_clk, i_rst_n, r_state == ST_SCAN, r_fresh == '0)
    `PJS_ASSERT_NEXT(a_tick_clean, i_clk, i_rst_n, w_accept && (w_func == FN_TICK),
                     (r_ptr == '0) && (r_emit_cnt == 4'd0))

endmodule

`default_nettype wire

FILE: dv/tb_periodic_job_scheduler.sv
`timescale 1ns / 1ps

module tb_periodic_job_scheduler;
    import pjs_pkg::*;

    localparam int SLOTS       = 8;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 150;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_WORDS = 300;

    typedef struct {
        t_func      fn;
        logic [2:0] slot;
        logic [6:0] prio;
        logic [7:0] period;
        logic [7:0] count;
        logic       forever_run;
        logic       typed;      // reply is written in the row
        t_status    typed_status;
    } t_stim;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    t_stim offer;
    logic  hold_req;

    // scheduler shadow state
    logic       sched_valid [SLOTS];
    logic       sched_fresh [SLOTS];
    logic       sched_cont  [SLOTS];
    logic [6:0] sched_prio  [SLOTS];
    logic [7:0] sched_period[SLOTS];
    logic [7:0] sched_cd    [SLOTS];
    logic [7:0] sched_left  [SLOTS];

    t_result pending_replies[$];
    int      mismatch_cnt;
    int      cycle_cnt;

    assign s_axis_tdata = {5'd0, offer.forever_run, offer.count, offer.period,
                           offer.prio, offer.slot};
    assign s_axis_tuser = offer.fn;

    periodic_job_scheduler #(.NUM_SLOTS(SLOTS)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic void push_reply(input logic [2:0] slot, input t_status st,
                                       input logic last);
        t_result r;
        r.slot   = slot;
        r.status = st;
        r.last   = last;
        pending_replies.push_back(r);
    endfunction

    // Apply one accepted word to the shadow table and queue the replies it causes.
    function automatic void schedule_word(input t_stim w);
        int      s;
        int      n;
        int      best;
        int      best_prio;
        int      run_slots[$];
        if (w.fn == FN_TICK) begin
            for (s = 0; s < SLOTS; s++) begin
                if (sched_valid[s]) begin
                    if (!sched_fresh[s] && sched_cd[s] != 8'd0)
                        sched_cd[s] = sched_cd[s] - 8'd1;
                end
                sched_fresh[s] = 1'b0;
            end
            for (n = 0; n < MAX_OUT; n++) begin
                best = -1;
                best_prio = 256;
                for (s = 0; s < SLOTS; s++) begin
                    if (sched_valid[s] && (sched_cont[s] || sched_left[s] != 8'd0) &&
                        sched_cd[s] == 8'd0 && int'(sched_prio[s]) < best_prio) begin
                        best = s;
                        best_prio = int'(sched_prio[s]);
                    end
                end
                if (best < 0)
                    break;
                sched_cd[best] = (sched_period[best] == 8'd0) ? 8'd1 : sched_period[best];
                if (!sched_cont[best])
                    sched_left[best] = sched_left[best] - 8'd1;
                run_slots.push_back(best);
            end
            if (run_slots.size() == 0)
                push_reply(3'd0, STAT_NONE_DUE, 1'b1);
            foreach (run_slots[i])
                push_reply(run_slots[i][2:0], STAT_OK, i == run_slots.size() - 1);
        end else if (w.fn == FN_ADD) begin
            if (sched_valid[w.slot]) begin
                push_reply(3'd0, STAT_USED, 1'b1);
            end else begin
                sched_valid[w.slot]  = 1'b1;
                sched_prio[w.slot]   = w.prio;
                sched_period[w.slot] = w.period;
                sched_cd[w.slot]     = (w.period == 8'd0) ? 8'd1 : w.period;
                sched_left[w.slot]   = w.count;
                sched_cont[w.slot]   = w.forever_run;
                sched_fresh[w.slot]  = 1'b1;
                push_reply(3'd0, STAT_OK, 1'b1);
            end
        end else if (!sched_valid[w.slot]) begin
            push_reply(3'd0, STAT_EMPTY, 1'b1);
        end else begin
            if (w.fn == FN_DEL) begin
                sched_valid[w.slot] = 1'b0;
                sched_fresh[w.slot] = 1'b0;
            end else begin
                sched_period[w.slot] = w.period;
                sched_prio[w.slot]   = w.prio;
            end
            push_reply(3'd0, STAT_OK, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                schedule_word(offer);
                if (offer.typed) begin
                    void'(pending_replies.pop_back());
                    push_reply(3'd0, offer.typed_status, 1'b1);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.slot   = m_axis_tdata[2:0];
                got.status = t_status'(m_axis_tuser);
                got.last   = m_axis_tlast;
                if (pending_replies.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected word: slot %0d status %0d last %0d",
                                 got.slot, got.status, got.last);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.slot !== want.slot || got.status !== want.status ||
                        got.last !== want.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: exp %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.slot, want.status, want.last,
                                     got.slot, got.status, got.last);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int  rx_left;
        logic rx_level;
        logic rx_held;
        rx_left  = 0;
        rx_level = 1'b0;
        rx_held  = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !rx_held) begin
                rx_held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                rx_left = 0;
            end else begin
                if (rx_left == 0) begin
                    rx_level = ~rx_level;
                    if (rx_level)
                        rx_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 15);
                    else
                        rx_left = $urandom_range(1, 5);
                end
                m_axis_tready <= rx_level;
                rx_left--;
            end
        end
    end

    function automatic logic [2:0] pick_slot(input logic want_used);
        int k;
        logic [2:0] s;
        for (k = 0; k < 8; k++) begin
            s = 3'($urandom_range(0, SLOTS - 1));
            if (sched_valid[s] == want_used)
                return s;
        end
        return 3'($urandom_range(0, SLOTS - 1));
    endfunction

    function automatic t_stim random_word();
        t_stim w;
        int    pick;
        pick = $urandom_range(0, 99);
        w.fn = (pick < 40) ? FN_TICK : (pick < 70) ? FN_ADD : (pick < 85) ? FN_DEL : FN_SET;
        if (w.fn == FN_ADD)
            w.slot = pick_slot($urandom_range(0, 4) == 0);
        else
            w.slot = pick_slot($urandom_range(0, 4) != 0);
        w.prio   = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 3))
                                               : 7'($urandom_range(0, 127));
        w.period = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        w.count = (pick < 7) ? 8'($urandom_range(1, 6)) :
                  (pick == 7) ? 8'd0 : 8'($urandom_range(0, 255));
        w.forever_run  = ($urandom_range(0, 3) == 0);
        w.typed        = 1'b0;
        w.typed_status = STAT_OK;
        return w;
    endfunction

    task automatic offer_word(input t_stim w);
        @(negedge i_clk);
        offer <= w;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic idle_for(input int n);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    initial begin
        t_stim directed_rows[$];
        int    burst_left;
        int    k;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        hold_req      = 1'b0;
        offer         = '{FN_TICK, 3'd0, 7'd0, 8'd0, 8'd0, 1'b0, 1'b0, STAT_OK};
        mismatch_cnt  = 0;
        cycle_cnt     = 0;
        for (k = 0; k < SLOTS; k++) begin
            sched_valid[k]  = 1'b0;
            sched_fresh[k]  = 1'b0;
            sched_cont[k]   = 1'b0;
            sched_prio[k]   = '0;
            sched_period[k] = '0;
            sched_cd[k]     = '0;
            sched_left[k]   = '0;
        end

        //                   func     slot  prio     period   count    forever typed status
        directed_rows.push_back('{FN_TICK, 3'd0, 7'd0,   8'd0,   8'd0,   1'b0, 1'b1, STAT_NONE_DUE});
        directed_rows.push_back('{FN_DEL,  3'd3, 7'd0,   8'd0,   8'd0,   1'b0, 1'b1, STAT_EMPTY});
        directed_rows.push_back('{FN_SET,  3'd7, 7'd127, 8'd255, 8'd255, 1'b1, 1'b1, STAT_EMPTY});
        directed_rows.push_back('{FN_ADD,  3'd0, 7'd0,   8'd0,   8'd3,   1'b0, 1'b1, STAT_OK});
        directed_rows.push_back('{FN_ADD,  3'd0, 7'd9,   8'd4,   8'd4,   1'b1, 1'b1, STAT_USED});
        directed_rows.push_back('{FN_ADD,  3'd7, 7'd127, 8'd255, 8'd255, 1'b1, 1'b0, STAT_OK});
        // zero runs and not continuous: holds the slot, never runs
        directed_rows.push_back('{FN_ADD,  3'd1, 7'd5,   8'd1,   8'd0,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_ADD,  3'd2, 7'd0,   8'd2,   8'd1,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_TICK, 3'd0, 7'd0,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_TICK, 3'd0, 7'd0,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_TICK, 3'd0, 7'd0,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});
        // set keeps the running countdown
        directed_rows.push_back('{FN_SET,  3'd0, 7'd3,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_TICK, 3'd0, 7'd0,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_DEL,  3'd1, 7'd0,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_ADD,  3'd1, 7'd64,  8'd1,   8'd0,   1'b1, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_DEL,  3'd2, 7'd0,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_ADD,  3'd2, 7'd0,   8'd1,   8'd5,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_ADD,  3'd3, 7'd1,   8'd1,   8'd2,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_ADD,  3'd4, 7'd1,   8'd1,   8'd200, 1'b1, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_ADD,  3'd5, 7'd2,   8'd1,   8'd255, 1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_ADD,  3'd6, 7'd0,   8'd0,   8'd1,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_DEL,  3'd7, 7'd0,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_ADD,  3'd7, 7'd127, 8'd1,   8'd0,   1'b1, 1'b0, STAT_OK});
        // slots 1 to 7 due at once on the second tick: seven words; slot 0 has no runs left
        directed_rows.push_back('{FN_TICK, 3'd0, 7'd0,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});
        directed_rows.push_back('{FN_TICK, 3'd0, 7'd0,   8'd0,   8'd0,   1'b0, 1'b0, STAT_OK});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_word(directed_rows[i]);

        // sender pause: let every reply drain
        idle_for(1);
        while (pending_replies.size() != 0) @(posedge i_clk);

        burst_left = 0;
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k == 80) begin
                @(negedge i_clk);
                hold_req <= 1'b1;
            end
            if (k == 160) begin
                idle_for(1);
                while (pending_replies.size() != 0) @(posedge i_clk);
            end
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0)
                    idle_for($urandom_range(1, 6));
                burst_left = ($urandom_range(0, 5) == 0) ? 30 : $urandom_range(1, 10);
            end
            offer_word(random_word());
            burst_left--;
        end
        idle_for(1);

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_replies.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/pjs_pkg.sv
sv/pjs_out_stage.sv
sv/periodic_job_scheduler.sv
dv/tb_periodic_job_scheduler.sv
